FILE: hw/rtl/stdma_pkg.sv
package stdma_pkg;

	localparam int ADDR_W     = 48;
	localparam int BYTE_W     = 8;
	localparam int PREFIX_W   = 24;
	localparam int INT_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int OUT_SLOT_W = 6;
	localparam int MOD_NW     = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_PREFIX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_SPAN = 2'd2;

	localparam logic [PREFIX_W-1:0] PREFIX_RST = 24'd1920;
	localparam logic [INT_W-1:0]    MIN_RST    = 4'd3;
	localparam logic [INT_W-1:0]    SPAN_RST   = 4'd4;

	typedef enum logic [1:0] {
		SS_FREE     = 2'd0,
		SS_EXTERNAL = 2'd2,
		SS_OWN      = 2'd3
	} slot_st_t;

	typedef enum logic [2:0] {
		AS_SLOT,
		AS_IDX,
		AS_OWN,
		AS_SCAN,
		AS_NEXT
	} addr_sel_t;

	typedef enum logic [1:0] {
		MS_PICK,
		MS_TIMEOUT
	} mod_sel_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_HEARD_START,
		CS_HEARD_WAIT,
		CS_HEARD_UPD,
		CS_TICK,
		CS_SWEEP,
		CS_OWN_CHK,
		CS_SCAN,
		CS_PICK_START,
		CS_PICK_WAIT,
		CS_TMO_START,
		CS_TMO_WAIT,
		CS_TX_CHK,
		CS_OFF_ADJ,
		CS_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic      capture;
		logic      mod_start;
		mod_sel_t  mod_sel;
		addr_sel_t addr_sel;
		logic      heard_upd;
		logic      tick_adv;
		logic      sweep;
		logic      scan_init;
		logic      scan_step;
		logic      pick_take;
		logic      claim;
		logic      tx_begin;
		logic      off_add;
		logic      off_final;
		logic      out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_tick;
		logic in_heard_ok;
		logic mod_busy;
		logic sc_wrap;
		logic idx_last;
		logic own_live;
		logic scan_last;
		logic own_match;
		logic off_low;
		logic out_free;
	} ctrl_sts_t;

endpackage

FILE: hw/rtl/stdma_mod.sv
module stdma_mod import stdma_pkg::*; #(
	parameter int DW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MOD_NW-1:0] dividend,
	input  logic [DW-1:0]     divisor,
	output logic              busy,
	output logic [MOD_NW-1:0] rem
);

	localparam int DQW    = DW + MOD_NW - 1;
	localparam int STEP_W = $clog2(MOD_NW);

	logic [MOD_NW-1:0] rem_q;
	logic [DQW-1:0]    d_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DQW-1:0]    rem_ext;
	logic [DQW-1:0]    diff;
	logic              ge;

	always_comb begin
		rem_ext = DQW'(rem_q);
		diff    = rem_ext - d_q;
		ge      = rem_ext >= d_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(MOD_NW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			d_q   <= {divisor, {(MOD_NW-1){1'b0}}};
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= MOD_NW'(diff);
			end
			d_q <= d_q >> 1;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

FILE: hw/rtl/stdma_dp.sv
module stdma_dp import stdma_pkg::*; #(
	parameter int SLOT_COUNT        = 8,
	parameter int SELECT_HALF_WIDTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  opcode,
	input  logic [ADDR_W-1:0]     sender_address,
	input  logic [BYTE_W-1:0]     heard_offset,
	input  logic [BYTE_W-1:0]     heard_timeout,
	input  logic [BYTE_W-1:0]     rand_pick,
	input  logic [BYTE_W-1:0]     rand_timeout,
	input  ctrl_cmd_t             cmd,
	output ctrl_sts_t             sts,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  stop_adv_start_scan,
	output logic                  transmit,
	output logic [OUT_SLOT_W-1:0] adv_offset,
	output logic [BYTE_W-1:0]     adv_timeout,
	output logic [OUT_SLOT_W-1:0] slot_now
);

	localparam int SW       = $clog2(SLOT_COUNT);
	localparam int CAND_MAX = 2 * SELECT_HALF_WIDTH + 2;
	localparam int CIW      = $clog2(CAND_MAX);
	localparam int CNW      = $clog2(CAND_MAX + 1);
	localparam int WW       = $clog2(2 * SELECT_HALF_WIDTH + 2);
	localparam int OFF_W    = $clog2(2 * SLOT_COUNT + 16);
	localparam int DW       = $clog2(SLOT_COUNT + 16);
	localparam int HK       = MOD_NW + SW;
	localparam int HMW      = MOD_NW + 2;
	localparam int HPW      = MOD_NW + HMW;

	localparam logic [SW-1:0]     SC_LAST  = SW'(SLOT_COUNT - 1);
	localparam logic [SW:0]       SC_X     = (SW + 1)'(SLOT_COUNT);
	localparam logic [SW:0]       HALF_X   = (SW + 1)'(SELECT_HALF_WIDTH);
	localparam logic [OFF_W-1:0]  SC_O     = OFF_W'(SLOT_COUNT);
	localparam logic [WW-1:0]     WIN_LAST = WW'(2 * SELECT_HALF_WIDTH);
	localparam logic [MOD_NW-1:0] SC_N     = MOD_NW'(SLOT_COUNT);
	localparam logic [HMW-1:0]    HM       = HMW'(((1 << HK) + SLOT_COUNT - 1) / SLOT_COUNT);

	logic [PREFIX_W-1:0] prefix_q;
	logic [INT_W-1:0]    min_q;
	logic [INT_W-1:0]    span_q;

	slot_st_t          st_q    [SLOT_COUNT];
	logic [BYTE_W-1:0] left_q  [SLOT_COUNT];
	logic [BYTE_W-1:0] hnext_q [SLOT_COUNT];

	logic [SW-1:0] sc_q;
	logic [SW-1:0] own_q;
	logic [SW-1:0] own_next_q;
	logic          was_tx_q;
	logic          skip_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] j_q;
	logic [CNW-1:0] cnt_q;
	logic [WW-1:0] wcnt_q;
	logic [SW-1:0] cand_q [CAND_MAX];

	logic [BYTE_W-1:0] h_off_q;
	logic [BYTE_W-1:0] h_to_q;
	logic [BYTE_W-1:0] r_pick_q;
	logic [BYTE_W-1:0] r_to_q;

	logic              stop_q;
	logic              tx_q;
	logic [OFF_W-1:0]  off_q;
	logic [BYTE_W-1:0] to_q;

	logic              out_valid_q;
	logic              o_stop_q;
	logic              o_tx_q;
	logic [OFF_W-1:0]  o_off_q;
	logic [BYTE_W-1:0] o_to_q;
	logic [SW-1:0]     o_slot_q;

	logic [MOD_NW-1:0] mod_rem;
	logic              mod_busy;
	logic [MOD_NW-1:0] mod_num;
	logic [DW-1:0]     mod_den;
	logic [INT_W-1:0]  span_eff;

	logic [MOD_NW-1:0] hsum;
	logic [HPW-1:0]    hprod;
	logic [MOD_NW-1:0] hback;
	logic [MOD_NW-1:0] hq_q;
	logic [SW-1:0]     hslot_q;

	logic [SW-1:0]     addr;
	slot_st_t          rd_st;
	logic [BYTE_W-1:0] rd_left;
	logic [BYTE_W-1:0] rd_next;
	logic [BYTE_W-1:0] sw_left;
	slot_st_t          sw_st;
	logic              heard_wr;
	logic [SW:0]       j_init;
	logic [OFF_W-1:0]  off_init;

	always_comb begin
		case (cmd.addr_sel)
			AS_SLOT: addr = hslot_q;
			AS_IDX:  addr = idx_q;
			AS_OWN:  addr = own_q;
			AS_SCAN: addr = j_q;
			AS_NEXT: addr = own_next_q;
			default: addr = idx_q;
		endcase
		rd_st   = st_q[addr];
		rd_left = left_q[addr];
		rd_next = hnext_q[addr];
	end

	always_comb begin
		sw_left = rd_left;
		sw_st   = rd_st;
		if (rd_next > rd_left) begin
			sw_left = rd_next;
			sw_st   = SS_EXTERNAL;
		end
		if (sw_left != '0) begin
			sw_left = sw_left - 1'b1;
		end
		if (sw_left == '0) begin
			sw_st = SS_FREE;
		end
	end

	always_comb begin
		span_eff = (span_q == '0) ? INT_W'(1) : span_q;
		case (cmd.mod_sel)
			MS_PICK: begin
				mod_num = MOD_NW'(r_pick_q);
				mod_den = DW'(cnt_q);
			end
			MS_TIMEOUT: begin
				mod_num = MOD_NW'(r_to_q);
				mod_den = DW'(span_eff);
			end
			default: begin
				mod_num = MOD_NW'(r_to_q);
				mod_den = DW'(span_eff);
			end
		endcase
	end

	// wrap the heard slot by reciprocal multiply
	always_comb begin
		hsum  = MOD_NW'(sc_q) + MOD_NW'(h_off_q);
		hprod = HPW'(hsum) * HPW'(HM);
		hback = hq_q * SC_N;
	end

	always_ff @(posedge clk) begin
		hq_q    <= MOD_NW'(hprod >> HK);
		hslot_q <= SW'(hsum - hback);
	end

	always_comb begin
		heard_wr = (addr != own_next_q) && (h_to_q > rd_next);
		j_init   = {1'b0, own_q} + SC_X - HALF_X;
		if (j_init >= SC_X) begin
			j_init = j_init - SC_X;
		end
		off_init = OFF_W'(own_next_q) + SC_O - OFF_W'(sc_q);
		if (off_init >= SC_O) begin
			off_init = off_init - SC_O;
		end
	end

	stdma_mod #(
		.DW(DW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (mod_num),
		.divisor  (mod_den),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= PREFIX_RST;
			min_q    <= MIN_RST;
			span_q   <= SPAN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VENDOR_PREFIX: prefix_q <= cfg_data[PREFIX_W-1:0];
				CFG_MIN_INTERVAL:  min_q    <= cfg_data[INT_W-1:0];
				CFG_INTERVAL_SPAN: span_q   <= cfg_data[INT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				st_q[i]    <= SS_FREE;
				left_q[i]  <= '0;
				hnext_q[i] <= '0;
			end
		end else begin
			if (cmd.heard_upd && heard_wr) begin
				hnext_q[addr] <= h_to_q;
			end
			if (cmd.sweep) begin
				hnext_q[addr] <= '0;
				left_q[addr]  <= sw_left;
				st_q[addr]    <= sw_st;
			end
			if (cmd.claim) begin
				st_q[addr]   <= SS_OWN;
				left_q[addr] <= BYTE_W'(mod_rem) + BYTE_W'(min_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q       <= '0;
			own_q      <= '0;
			own_next_q <= '0;
			was_tx_q   <= 1'b0;
			skip_q     <= 1'b0;
			idx_q      <= '0;
			j_q        <= '0;
			cnt_q      <= '0;
			wcnt_q     <= '0;
		end else begin
			if (cmd.tick_adv) begin
				was_tx_q <= 1'b0;
				idx_q    <= '0;
				if (sc_q == SC_LAST) begin
					sc_q   <= '0;
					skip_q <= 1'b0;
				end else begin
					sc_q <= sc_q + 1'b1;
				end
			end
			if (cmd.sweep) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.scan_init) begin
				j_q    <= j_init[SW-1:0];
				cnt_q  <= CNW'(1);
				wcnt_q <= '0;
			end
			if (cmd.scan_step) begin
				j_q    <= (j_q == SC_LAST) ? '0 : j_q + 1'b1;
				wcnt_q <= wcnt_q + 1'b1;
				if (rd_st == SS_FREE) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.pick_take) begin
				own_next_q <= cand_q[mod_rem[CIW-1:0]];
			end
			if (cmd.tx_begin) begin
				own_q    <= own_next_q;
				was_tx_q <= 1'b1;
			end
			if (cmd.off_final) begin
				skip_q <= off_q > SC_O;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			h_off_q  <= heard_offset;
			h_to_q   <= heard_timeout;
			r_pick_q <= rand_pick;
			r_to_q   <= rand_timeout;
		end
		if (cmd.scan_init) begin
			cand_q[0] <= own_q;
		end
		if (cmd.scan_step && rd_st == SS_FREE) begin
			cand_q[cnt_q[CIW-1:0]] <= j_q;
		end
		if (cmd.tick_adv) begin
			stop_q <= was_tx_q;
			tx_q   <= 1'b0;
			off_q  <= '0;
			to_q   <= '0;
		end
		if (cmd.tx_begin) begin
			tx_q  <= 1'b1;
			off_q <= off_init;
		end
		if (cmd.off_add) begin
			off_q <= off_q + SC_O;
		end
		if (cmd.off_final) begin
			to_q <= rd_left;
		end
		if (cmd.out_load) begin
			o_stop_q <= stop_q;
			o_tx_q   <= tx_q;
			o_off_q  <= off_q;
			o_to_q   <= to_q;
			o_slot_q <= sc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.in_tick     = !opcode;
		sts.in_heard_ok = opcode && (sender_address[ADDR_W-1:ADDR_W-PREFIX_W] == prefix_q);
		sts.mod_busy    = mod_busy;
		sts.sc_wrap     = sc_q == SC_LAST;
		sts.idx_last    = idx_q == SC_LAST;
		sts.own_live    = rd_left != '0;
		sts.scan_last   = wcnt_q == WIN_LAST;
		sts.own_match   = (sc_q == own_q) && !skip_q;
		sts.off_low     = off_q <= OFF_W'(span_q);
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid           = out_valid_q;
	assign stop_adv_start_scan = o_stop_q;
	assign transmit            = o_tx_q;
	assign adv_offset          = OUT_SLOT_W'(o_off_q);
	assign adv_timeout         = o_to_q;
	assign slot_now            = OUT_SLOT_W'(o_slot_q);

endmodule

FILE: hw/rtl/stdma_ctrl.sv
module stdma_ctrl import stdma_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid) begin
					if (sts.in_tick) begin
						state_d = CS_TICK;
					end else if (sts.in_heard_ok) begin
						state_d = CS_HEARD_START;
					end
				end
			end
			CS_HEARD_START: state_d = CS_HEARD_WAIT;
			CS_HEARD_WAIT: state_d = CS_HEARD_UPD;
			CS_HEARD_UPD: state_d = CS_IDLE;
			CS_TICK: state_d = sts.sc_wrap ? CS_SWEEP : CS_TX_CHK;
			CS_SWEEP: begin
				if (sts.idx_last) begin
					state_d = CS_OWN_CHK;
				end
			end
			CS_OWN_CHK: state_d = sts.own_live ? CS_TX_CHK : CS_SCAN;
			CS_SCAN: begin
				if (sts.scan_last) begin
					state_d = CS_PICK_START;
				end
			end
			CS_PICK_START: state_d = CS_PICK_WAIT;
			CS_PICK_WAIT: begin
				if (!sts.mod_busy) begin
					state_d = CS_TMO_START;
				end
			end
			CS_TMO_START: state_d = CS_TMO_WAIT;
			CS_TMO_WAIT: begin
				if (!sts.mod_busy) begin
					state_d = CS_TX_CHK;
				end
			end
			CS_TX_CHK: state_d = sts.own_match ? CS_OFF_ADJ : CS_RESULT;
			CS_OFF_ADJ: begin
				if (!sts.off_low) begin
					state_d = CS_RESULT;
				end
			end
			CS_RESULT: begin
				if (sts.out_free) begin
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mod_sel  = MS_PICK;
		cmd.addr_sel = AS_IDX;
		in_ready     = 1'b0;
		case (state_q)
			CS_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			CS_HEARD_START: ;
			CS_HEARD_WAIT: ;
			CS_HEARD_UPD: begin
				cmd.heard_upd = 1'b1;
				cmd.addr_sel  = AS_SLOT;
			end
			CS_TICK: cmd.tick_adv = 1'b1;
			CS_SWEEP: begin
				cmd.sweep    = 1'b1;
				cmd.addr_sel = AS_IDX;
			end
			CS_OWN_CHK: begin
				cmd.scan_init = 1'b1;
				cmd.addr_sel  = AS_OWN;
			end
			CS_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.addr_sel  = AS_SCAN;
			end
			CS_PICK_START: begin
				cmd.mod_start = 1'b1;
				cmd.mod_sel   = MS_PICK;
			end
			CS_PICK_WAIT: cmd.pick_take = !sts.mod_busy;
			CS_TMO_START: begin
				cmd.mod_start = 1'b1;
				cmd.mod_sel   = MS_TIMEOUT;
			end
			CS_TMO_WAIT: begin
				cmd.claim    = !sts.mod_busy;
				cmd.addr_sel = AS_NEXT;
			end
			CS_TX_CHK: cmd.tx_begin = sts.own_match;
			CS_OFF_ADJ: begin
				cmd.addr_sel  = AS_OWN;
				cmd.off_add   = sts.off_low;
				cmd.off_final = !sts.off_low;
			end
			CS_RESULT: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/stdma_slot_reservation.sv
// Self-organized TDMA slot reservation. A heard word (opcode 1) from a sender
// whose upper three address bytes match vendor_prefix notes the neighbor's
// timeout for the slot it announced; the reciprocal multiply that wraps the
// offset onto a slot registers its quotient and then the slot, and a word from
// a foreign sender is taken and dropped. A tick word (opcode 0) advances the
// slot and always returns one result word; without a frame end its run length
// depends on the own-slot check and the loop that brings the advertised offset
// into range. At a frame end the table is walked one slot per cycle, and if the
// own slot has expired the selection window is walked one slot per cycle and
// two 9-step passes of the modulo unit pick the new slot and its lifetime. One
// word is in work at a time; a finished result sits in an output register, so
// the next word is taken while it waits. The slot table is cleared by reset at
// once and needs no clearing pass.
module stdma_slot_reservation import stdma_pkg::*; #(
	parameter int SLOT_COUNT        = 8,
	parameter int SELECT_HALF_WIDTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [ADDR_W-1:0]     sender_address,
	input  logic [BYTE_W-1:0]     heard_offset,
	input  logic [BYTE_W-1:0]     heard_timeout,
	input  logic [BYTE_W-1:0]     rand_pick,
	input  logic [BYTE_W-1:0]     rand_timeout,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  stop_adv_start_scan,
	output logic                  transmit,
	output logic [OUT_SLOT_W-1:0] adv_offset,
	output logic [BYTE_W-1:0]     adv_timeout,
	output logic [OUT_SLOT_W-1:0] slot_now
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	stdma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stdma_dp #(
		.SLOT_COUNT        (SLOT_COUNT),
		.SELECT_HALF_WIDTH (SELECT_HALF_WIDTH)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.opcode              (opcode),
		.sender_address      (sender_address),
		.heard_offset        (heard_offset),
		.heard_timeout       (heard_timeout),
		.rand_pick           (rand_pick),
		.rand_timeout        (rand_timeout),
		.cmd                 (cmd),
		.sts                 (sts),
		.out_ready           (out_ready),
		.out_valid           (out_valid),
		.stop_adv_start_scan (stop_adv_start_scan),
		.transmit            (transmit),
		.adv_offset          (adv_offset),
		.adv_timeout         (adv_timeout),
		.slot_now            (slot_now)
	);

endmodule

FILE: test/stdma_slot_reservation_test.sv
`timescale 1ns / 100ps

module stdma_slot_reservation_test;
	import stdma_pkg::*;

	localparam int SLOTS    = 8;
	localparam int HALF     = 2;
	localparam int CAND_MAX = 2 * HALF + 2;
	localparam int WATCHDOG = 3000;
	localparam int SETTLE   = 80;
	localparam int HOLD_LEN = 400;
	localparam int PHASE_N  = 320;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_HEARD = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic                  opcode;
		logic [ADDR_W-1:0]     address;
		logic [BYTE_W-1:0]     offset;
		logic [BYTE_W-1:0]     timeout;
		logic [BYTE_W-1:0]     pick;
		logic [BYTE_W-1:0]     life_rand;
	} air_word_t;

	typedef struct packed {
		logic                  stop_scan;
		logic                  tx;
		logic [OUT_SLOT_W-1:0] offset;
		logic [BYTE_W-1:0]     timeout;
		logic [OUT_SLOT_W-1:0] slot;
	} slot_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  opcode = 1'b0;
	logic [ADDR_W-1:0]     sender_address = '0;
	logic [BYTE_W-1:0]     heard_offset = '0;
	logic [BYTE_W-1:0]     heard_timeout = '0;
	logic [BYTE_W-1:0]     rand_pick = '0;
	logic [BYTE_W-1:0]     rand_timeout = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  stop_adv_start_scan;
	logic                  transmit;
	logic [OUT_SLOT_W-1:0] adv_offset;
	logic [BYTE_W-1:0]     adv_timeout;
	logic [OUT_SLOT_W-1:0] slot_now;

	stdma_slot_reservation #(
		.SLOT_COUNT(SLOTS),
		.SELECT_HALF_WIDTH(HALF)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.sender_address(sender_address),
		.heard_offset(heard_offset),
		.heard_timeout(heard_timeout),
		.rand_pick(rand_pick),
		.rand_timeout(rand_timeout),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stop_adv_start_scan(stop_adv_start_scan),
		.transmit(transmit),
		.adv_offset(adv_offset),
		.adv_timeout(adv_timeout),
		.slot_now(slot_now)
	);

	// predictor state
	logic [PREFIX_W-1:0] cur_prefix = PREFIX_RST;
	logic [INT_W-1:0]    cur_min = MIN_RST;
	logic [INT_W-1:0]    cur_span = SPAN_RST;
	slot_st_t            tbl_state [SLOTS];
	logic [BYTE_W-1:0]   tbl_left [SLOTS];
	logic [BYTE_W-1:0]   tbl_heard [SLOTS];
	int                  cur_slot = 0;
	int                  my_slot = 0;
	int                  my_next = 0;
	bit                  sent_last = 1'b0;
	bit                  skip_rest = 1'b0;

	air_word_t    words_to_send [$];
	slot_report_t reports_due [$];
	air_word_t    drive_word;
	slot_report_t rep, got, want;
	logic         word_taken = 1'b0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           stall_asks = 0;
	int           stalls_done = 0;
	int           hold_left = 0;
	int           idle_cycles = 0;
	int           fault_count = 0;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_state[i] = SS_FREE;
			tbl_left[i]  = '0;
			tbl_heard[i] = '0;
		end
	end

	function automatic void close_frame(input logic [BYTE_W-1:0] pick,
			input logic [BYTE_W-1:0] life_rand);
		int cand [CAND_MAX];
		int count;
		int j;
		int span;
		for (int i = 0; i < SLOTS; i++) begin
			if (tbl_heard[i] > tbl_left[i]) begin
				tbl_left[i]  = tbl_heard[i];
				tbl_state[i] = SS_EXTERNAL;
			end
			tbl_heard[i] = '0;
			if (tbl_left[i] != 0)
				tbl_left[i] = tbl_left[i] - 1;
			if (tbl_left[i] == 0)
				tbl_state[i] = SS_FREE;
		end
		if (tbl_left[my_slot] != 0)
			return;
		count = 1;
		cand[0] = my_slot;
		for (int k = 0; k <= 2 * HALF; k++) begin
			j = (my_slot + SLOTS - HALF + k) % SLOTS;
			if (tbl_state[j] == SS_FREE && count < CAND_MAX) begin
				cand[count] = j;
				count++;
			end
		end
		my_next = cand[pick % count];
		tbl_state[my_next] = SS_OWN;
		span = (cur_span == 0) ? 1 : cur_span;
		tbl_left[my_next] = BYTE_W'((life_rand % span + cur_min) & 8'hFF);
	endfunction

	// returns 1 when the word yields a report
	function automatic bit reserve_step(input air_word_t w, output slot_report_t r);
		int slot;
		int off;
		r = '0;
		if (w.opcode == OP_HEARD) begin
			if (w.address[ADDR_W-1 -: PREFIX_W] != cur_prefix)
				return 1'b0;
			slot = (cur_slot + w.offset) % SLOTS;
			if (slot != my_next && w.timeout > tbl_heard[slot])
				tbl_heard[slot] = w.timeout;
			return 1'b0;
		end
		r.stop_scan = sent_last;
		sent_last = 1'b0;
		cur_slot = (cur_slot + 1) % SLOTS;
		if (cur_slot == 0) begin
			skip_rest = 1'b0;
			close_frame(w.pick, w.life_rand);
		end
		if (cur_slot == my_slot && !skip_rest) begin
			my_slot = my_next;
			off = (my_slot + SLOTS - cur_slot) % SLOTS;
			while (off <= cur_span)
				off += SLOTS;
			if (off > SLOTS)
				skip_rest = 1'b1;
			r.timeout = tbl_left[my_slot];
			r.offset = OUT_SLOT_W'(off);
			r.tx = 1'b1;
			sent_last = 1'b1;
		end
		r.slot = OUT_SLOT_W'(cur_slot);
		return 1'b1;
	endfunction

	function automatic air_word_t mk_word(input logic op, input logic [PREFIX_W-1:0] hi,
			input int off, input int to, input int pick, input int life);
		air_word_t w;
		w.opcode    = op;
		w.address   = {hi, PREFIX_W'($urandom)};
		w.offset    = BYTE_W'(off);
		w.timeout   = BYTE_W'(to);
		w.pick      = BYTE_W'(pick);
		w.life_rand = BYTE_W'(life);
		return w;
	endfunction

	// mostly ticks and in-prefix announcements, some foreign senders
	function automatic air_word_t random_word();
		int kind;
		int to;
		logic [PREFIX_W-1:0] hi;
		kind = $urandom_range(99);
		to = ($urandom_range(9) < 7) ? $urandom_range(12) : $urandom_range(255);
		if (kind < 15)
			hi = PREFIX_W'($urandom);
		else
			hi = cur_prefix;
		if (hi == cur_prefix && kind < 15)
			hi = hi ^ (PREFIX_W'(1) << $urandom_range(PREFIX_W - 1));
		return mk_word(kind < 55 ? OP_HEARD : OP_TICK, hi, $urandom_range(255), to,
			$urandom_range(255), $urandom_range(255));
	endfunction

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		case (idx)
			CFG_VENDOR_PREFIX: cur_prefix = d[PREFIX_W-1:0];
			CFG_MIN_INTERVAL:  cur_min = d[INT_W-1:0];
			CFG_INTERVAL_SPAN: cur_span = d[INT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_random(input int n);
		for (int k = 0; k < n; k++)
			words_to_send.push_back(random_word());
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (words_to_send.size() != 0 || in_valid || reports_due.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || word_taken) begin
			if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drive_word = words_to_send.pop_front();
				in_valid       <= 1'b1;
				opcode         <= drive_word.opcode;
				sender_address <= drive_word.address;
				heard_offset   <= drive_word.offset;
				heard_timeout  <= drive_word.timeout;
				rand_pick      <= drive_word.pick;
				rand_timeout   <= drive_word.life_rand;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_asks != stalls_done) begin
				stalls_done = stall_asks;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			word_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				if (reserve_step('{opcode, sender_address, heard_offset, heard_timeout,
						rand_pick, rand_timeout}, rep))
					reports_due.push_back(rep);
			end
			if (out_valid && out_ready) begin
				got = '{stop_adv_start_scan, transmit, adv_offset, adv_timeout, slot_now};
				if (reports_due.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected word: scan=%0d tx=%0d off=%0d to=%0d slot=%0d",
							got.stop_scan, got.tx, got.offset, got.timeout, got.slot);
				end else begin
					want = reports_due.pop_front();
					if (got.stop_scan !== want.stop_scan || got.tx !== want.tx ||
							got.offset !== want.offset || got.timeout !== want.timeout ||
							got.slot !== want.slot) begin
						fault_count++;
						if (fault_count <= 10)
							$display("mismatch: exp scan=%0d tx=%0d off=%0d to=%0d slot=%0d, got scan=%0d tx=%0d off=%0d to=%0d slot=%0d",
								want.stop_scan, want.tx, want.offset, want.timeout, want.slot,
								got.stop_scan, got.tx, got.offset, got.timeout, got.slot);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("stdma_slot_reservation_test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 17;
		recv_idle_pct = 55;
		// own next slot, fresh note, smaller note, wrapped offset, foreign senders
		words_to_send.push_back(mk_word(OP_HEARD, cur_prefix, 0, 200, 0, 0));
		words_to_send.push_back(mk_word(OP_HEARD, cur_prefix, 1, 5, 255, 255));
		words_to_send.push_back(mk_word(OP_HEARD, cur_prefix, 9, 3, 0, 0));
		words_to_send.push_back(mk_word(OP_HEARD, cur_prefix, 255, 255, 0, 0));
		words_to_send.push_back(mk_word(OP_HEARD, cur_prefix ^ 24'h000001, 2, 9, 0, 0));
		words_to_send.push_back(mk_word(OP_HEARD, cur_prefix ^ 24'h800000, 3, 9, 0, 0));
		words_to_send.push_back(mk_word(OP_HEARD, cur_prefix, 2, 0, 0, 0));
		for (int k = 0; k < 8; k++)
			words_to_send.push_back(mk_word(OP_TICK, PREFIX_W'($urandom), $urandom_range(255),
				$urandom_range(255), 255, 255));
		words_to_send.push_back(mk_word(OP_HEARD, cur_prefix, 6, 4, 0, 0));
		for (int k = 0; k < 8; k++)
			words_to_send.push_back(mk_word(OP_TICK, cur_prefix, 0, 0, 0, 0));
		push_random(PHASE_N);
		settle();

		send_idle_pct = 55;
		recv_idle_pct = 17;
		set_reg(CFG_VENDOR_PREFIX, 24'h000000);
		set_reg(CFG_MIN_INTERVAL, 24'd1);
		set_reg(CFG_INTERVAL_SPAN, 24'd1);
		push_random(PHASE_N);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_reg(CFG_VENDOR_PREFIX, 24'hFFFFFF);
		set_reg(CFG_MIN_INTERVAL, 24'd15);
		set_reg(CFG_INTERVAL_SPAN, 24'd15);
		push_random(PHASE_N);
		repeat (40) @(negedge clk);
		stall_asks++;
		settle();

		// zero span falls back to the minimum lifetime
		set_reg(CFG_VENDOR_PREFIX, PREFIX_W'($urandom));
		set_reg(CFG_MIN_INTERVAL, 24'd2);
		set_reg(CFG_INTERVAL_SPAN, 24'd0);
		push_random(PHASE_N);
		settle();

		set_reg(CFG_SPARE, CFG_DATA_W'($urandom));
		set_reg(CFG_VENDOR_PREFIX, PREFIX_W'($urandom));
		set_reg(CFG_MIN_INTERVAL, CFG_DATA_W'($urandom_range(1, 15)));
		set_reg(CFG_INTERVAL_SPAN, 24'd7);
		push_random(PHASE_N);
		settle();

		if (fault_count == 0 && reports_due.size() == 0)
			$display("stdma_slot_reservation_test passed");
		else
			$display("stdma_slot_reservation_test failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/stdma_pkg.sv
hw/rtl/stdma_mod.sv
hw/rtl/stdma_dp.sv
hw/rtl/stdma_ctrl.sv
hw/rtl/stdma_slot_reservation.sv
test/stdma_slot_reservation_test.sv
